@@ rtl/core/jsu_pkg.sv @@
// shared types, codes and helpers for the json string unescape unit
package jsu_pkg;

  // input item: one byte of text or the end marker
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;
  } out_item_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_EXPECTED_STRING = 3'd0,
    ERR_END_IN_ESCAPE   = 3'd1,
    ERR_TRUNCATED_U     = 3'd2,
    ERR_BAD_HEX         = 3'd3,
    ERR_UNKNOWN_ESCAPE  = 3'd4,
    ERR_UNTERMINATED    = 3'd5
  } err_code_t;

  // front end parser states
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_HEX,
    MODE_HEXBAD,
    MODE_DROP
  } mode_t;

  // work handed from front to back
  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_DONE,
    CMD_ERR,
    CMD_UTF8
  } cmd_op_t;

  // byte, error code or code point in the low bits of data
  typedef struct packed {
    cmd_op_t     op;
    logic [15:0] data;
  } cmd_t;

  localparam logic [7:0]  CH_QUOTE     = 8'h22;
  localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
  localparam logic [7:0]  CH_SLASH     = 8'h2F;
  localparam logic [7:0]  CH_LC_B      = 8'h62;
  localparam logic [7:0]  CH_LC_F      = 8'h66;
  localparam logic [7:0]  CH_LC_N      = 8'h6E;
  localparam logic [7:0]  CH_LC_R      = 8'h72;
  localparam logic [7:0]  CH_LC_T      = 8'h74;
  localparam logic [7:0]  CH_LC_U      = 8'h75;
  localparam logic [7:0]  CH_BS        = 8'h08;
  localparam logic [7:0]  CH_FF        = 8'h0C;
  localparam logic [7:0]  CH_LF        = 8'h0A;
  localparam logic [7:0]  CH_CR        = 8'h0D;
  localparam logic [7:0]  CH_TAB       = 8'h09;

  localparam logic [15:0] UTF8_LIM1    = 16'h0080;
  localparam logic [15:0] UTF8_LIM2    = 16'h0800;
  localparam logic [7:0]  UTF8_CONT    = 8'h80;
  localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
  localparam logic [7:0]  UTF8_MASK6   = 8'h3F;

  // hex digit decode, either case; bit 4 flags a valid digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

@@ rtl/core/jsu_front.sv @@
// front end: accepts text items, tracks string state and issues commands
module jsu_front import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t in_item,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  mode_t       mode, mode_next;
  logic [15:0] code_point, code_point_next;
  logic [1:0]  hex_count, hex_count_next;
  logic        produce;
  logic        accept;
  logic [4:0]  hx;
  logic [15:0] cp_shift;
  logic        bad;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && produce;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      code_point <= '0;
      hex_count  <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      code_point <= code_point_next;
      hex_count  <= hex_count_next;
    end
  end

  assign hx       = hex_decode(in_item.in_byte);
  assign cp_shift = hx[4] ? {code_point[11:0], hx[3:0]} : code_point;
  assign bad      = (mode == MODE_HEXBAD) || !hx[4];

  // classify the item and pick the next state
  always_comb begin
    mode_next       = mode;
    code_point_next = code_point;
    hex_count_next  = hex_count;
    produce         = 1'b0;
    q_cmd.op        = CMD_BYTE;
    q_cmd.data      = '0;
    if (in_item.end_of_text) begin
      mode_next       = MODE_IDLE;
      code_point_next = '0;
      hex_count_next  = '0;
      q_cmd.op        = CMD_ERR;
      unique case (mode)
        MODE_STR: begin
          produce    = 1'b1;
          q_cmd.data = {13'd0, ERR_UNTERMINATED};
        end
        MODE_ESC: begin
          produce    = 1'b1;
          q_cmd.data = {13'd0, ERR_END_IN_ESCAPE};
        end
        MODE_HEX, MODE_HEXBAD: begin
          produce    = 1'b1;
          q_cmd.data = {13'd0, ERR_TRUNCATED_U};
        end
        default: produce = 1'b0;
      endcase
    end else begin
      unique case (mode)
        MODE_IDLE: begin
          if (in_item.in_byte == CH_QUOTE) begin
            mode_next = MODE_STR;
          end else begin
            mode_next  = MODE_DROP;
            produce    = 1'b1;
            q_cmd.op   = CMD_ERR;
            q_cmd.data = {13'd0, ERR_EXPECTED_STRING};
          end
        end
        MODE_STR: begin
          if (in_item.in_byte == CH_QUOTE) begin
            mode_next = MODE_IDLE;
            produce   = 1'b1;
            q_cmd.op  = CMD_DONE;
          end else if (in_item.in_byte == CH_BACKSLASH) begin
            mode_next = MODE_ESC;
          end else begin
            produce    = 1'b1;
            q_cmd.data = {8'd0, in_item.in_byte};
          end
        end
        MODE_ESC: begin
          mode_next = MODE_STR;
          produce   = 1'b1;
          unique case (in_item.in_byte)
            CH_QUOTE:     q_cmd.data = {8'd0, CH_QUOTE};
            CH_BACKSLASH: q_cmd.data = {8'd0, CH_BACKSLASH};
            CH_SLASH:     q_cmd.data = {8'd0, CH_SLASH};
            CH_LC_B:      q_cmd.data = {8'd0, CH_BS};
            CH_LC_F:      q_cmd.data = {8'd0, CH_FF};
            CH_LC_N:      q_cmd.data = {8'd0, CH_LF};
            CH_LC_R:      q_cmd.data = {8'd0, CH_CR};
            CH_LC_T:      q_cmd.data = {8'd0, CH_TAB};
            CH_LC_U: begin
              mode_next       = MODE_HEX;
              produce         = 1'b0;
              code_point_next = '0;
              hex_count_next  = '0;
            end
            default: begin
              mode_next  = MODE_DROP;
              q_cmd.op   = CMD_ERR;
              q_cmd.data = {13'd0, ERR_UNKNOWN_ESCAPE};
            end
          endcase
        end
        MODE_HEX, MODE_HEXBAD: begin
          if (hex_count != 2'd3) begin
            hex_count_next  = hex_count + 2'd1;
            code_point_next = cp_shift;
            mode_next       = bad ? MODE_HEXBAD : MODE_HEX;
          end else begin
            hex_count_next  = '0;
            code_point_next = '0;
            produce         = 1'b1;
            if (bad) begin
              mode_next  = MODE_DROP;
              q_cmd.op   = CMD_ERR;
              q_cmd.data = {13'd0, ERR_BAD_HEX};
            end else begin
              mode_next  = MODE_STR;
              q_cmd.op   = CMD_UTF8;
              q_cmd.data = cp_shift;
            end
          end
        end
        default: produce = 1'b0;
      endcase
    end
  end

endmodule

@@ rtl/core/jsu_cmd_fifo.sv @@
// short command queue between front and back
module jsu_cmd_fifo import jsu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == FULL_CNT);
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/jsu_back.sv @@
// back end: expands commands into result items through an output register
module jsu_back import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      head,
  input  logic      empty,
  output logic      pop,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready
);

  logic [1:0] beat_idx;
  logic [1:0] beat_cnt;
  logic       load;
  logic       final_beat;
  out_item_t  beat;
  logic [15:0] cp;

  assign cp         = head.data;
  assign load       = !empty && (!out_valid || out_ready);
  assign final_beat = (beat_idx == beat_cnt - 2'd1);
  assign pop        = load && final_beat;

  // beats per command and the current beat
  always_comb begin
    beat            = '0;
    beat_cnt        = 2'd1;
    unique case (head.op)
      CMD_BYTE: beat.out_byte = cp[7:0];
      CMD_DONE: beat.kind     = KIND_DONE;
      CMD_ERR: begin
        beat.kind       = KIND_ERR;
        beat.error_code = cp[2:0];
      end
      CMD_UTF8: begin
        if (cp < UTF8_LIM1) begin
          beat.out_byte = cp[7:0];
        end else if (cp < UTF8_LIM2) begin
          beat_cnt = 2'd2;
          if (beat_idx == 2'd0) begin
            beat.out_byte = UTF8_LEAD2 | {3'd0, cp[10:6]};
          end else begin
            beat.out_byte = UTF8_CONT | (UTF8_MASK6 & {2'd0, cp[5:0]});
          end
        end else begin
          beat_cnt = 2'd3;
          if (beat_idx == 2'd0) begin
            beat.out_byte = UTF8_LEAD3 | {4'd0, cp[15:12]};
          end else if (beat_idx == 2'd1) begin
            beat.out_byte = UTF8_CONT | (UTF8_MASK6 & {2'd0, cp[11:6]});
          end else begin
            beat.out_byte = UTF8_CONT | (UTF8_MASK6 & {2'd0, cp[5:0]});
          end
        end
      end
      default: beat = '0;
    endcase
    // final beat of the command carries last
    beat.last = (beat_idx == beat_cnt - 2'd1);
  end

  // beat counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        beat_idx  <= final_beat ? 2'd0 : beat_idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= beat;
    end
  end

endmodule

@@ rtl/core/json_string_unescape_unit.sv @@
// top level of the json string unescape unit
//
// in channel: one byte of json text per transfer, or an end-of-text marker
// (in_item, in_valid, in_ready). out channel: decoded bytes, string-complete
// and error results (out_item, out_valid, out_ready); last marks the final
// result caused by one input transfer.
// the front end takes one input item per cycle whenever the command queue
// has room; each item that yields results leaves one command in the queue.
// the back end turns a command into one result, or one to three utf-8
// bytes for a \u escape, through an output register at one result per cycle
// while out_ready is high. the first result of an item goes through the
// command queue and then the output register. throughput: one item per
// cycle, set by the back end's single result per cycle; results never
// outnumber the input bytes that caused them, so a steady stream runs
// without stalls while out_ready is high; if the receiver stalls, the queue
// (QUEUE_DEPTH commands) fills and then in_ready drops until room frees up.
// reset clears the parser to idle (awaiting an opening quote) and empties
// the queue and output register.
module json_string_unescape_unit import jsu_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      in_valid,
  output logic      in_ready,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_cmd;
  cmd_t q_head;

  // parser
  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // command queue
  jsu_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // result generator
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
